@@ design/fpv_pkg.sv @@
// Package with the status codes, segment state type and character classes of the path validator.
`default_nettype none

package fpv_pkg;

	localparam int SEG_LEN_W = 8;
	localparam int EXT_LEN_W = 3;
	localparam int MAX_SEG_LEN_DEF = 255;
	localparam int EXT_LEN_SAT = 4;
	localparam int EXT_LEN_MAX = 3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_UNDER = 8'h5F;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_LONG    = 3'd2,
		ST_DIRCHAR = 3'd3,
		ST_BADCHAR = 3'd4,
		ST_EXTLEN  = 3'd5
	} status_t;

	typedef struct packed {
		logic                 at_first;
		logic                 bypass;
		status_t              err_code;
		logic [SEG_LEN_W-1:0] seg_len;
		logic                 seg_has_dot;
		logic                 seg_bad_char;
		logic [EXT_LEN_W-1:0] ext_len;
		logic                 ext_nonalpha;
	} seg_state_t;

	localparam seg_state_t STATE_RESET = '{
		at_first:     1'b1,
		bypass:       1'b0,
		err_code:     ST_OK,
		seg_len:      '0,
		seg_has_dot:  1'b0,
		seg_bad_char: 1'b0,
		ext_len:      '0,
		ext_nonalpha: 1'b0
	};

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER;
	endfunction

endpackage

`default_nettype wire

@@ design/fpv_if.sv @@
// Valid/ready channel interfaces for path bytes and for result status.
`default_nettype none

interface fpv_path_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface fpv_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

`default_nettype wire

@@ design/fpv_step.sv @@
// Next-state and final-status logic for one path byte.
`default_nettype none

module fpv_step
	import fpv_pkg::*;
#(
	parameter int MAX_SEG_LEN = MAX_SEG_LEN_DEF
) (
	input  seg_state_t cur,
	input  logic [7:0] ch,
	input  logic       last,
	output seg_state_t nxt,
	output status_t    status
);

	localparam logic [SEG_LEN_W-1:0] SEG_LIMIT = SEG_LEN_W'(MAX_SEG_LEN);

	seg_state_t upd;

	always_comb begin
		upd = cur;
		if (cur.at_first) begin
			upd.at_first = 1'b0;
			upd.bypass = (ch != CH_SLASH);
		end else if (cur.bypass || cur.err_code != ST_OK) begin
			upd = cur;
		end else if (ch == CH_SLASH) begin
			if (cur.seg_len == '0) begin
				upd.err_code = ST_EMPTY;
			end else if (cur.seg_bad_char || cur.seg_has_dot) begin
				upd.err_code = ST_DIRCHAR;
			end
			upd.seg_len = '0;
			upd.seg_has_dot = 1'b0;
			upd.seg_bad_char = 1'b0;
			upd.ext_len = '0;
			upd.ext_nonalpha = 1'b0;
		end else if (cur.seg_len >= SEG_LIMIT) begin
			upd.err_code = ST_LONG;
		end else begin
			upd.seg_len = cur.seg_len + 1'b1;
			if (ch == CH_DOT) begin
				upd.seg_has_dot = 1'b1;
				upd.ext_len = '0;
				upd.ext_nonalpha = 1'b0;
			end else begin
				if (!is_name_char(ch)) begin
					upd.seg_bad_char = 1'b1;
				end
				if (cur.ext_len < EXT_LEN_W'(EXT_LEN_SAT)) begin
					upd.ext_len = cur.ext_len + 1'b1;
				end
				if (!is_letter(ch)) begin
					upd.ext_nonalpha = 1'b1;
				end
			end
		end
	end

	// Final status is judged on the state after this byte.
	always_comb begin
		priority if (upd.bypass || upd.err_code != ST_OK) begin
			status = upd.err_code;
		end else if (upd.seg_len == '0) begin
			status = ST_OK;
		end else if (upd.seg_bad_char) begin
			status = ST_BADCHAR;
		end else if (upd.seg_has_dot &&
				(upd.ext_len == '0 || upd.ext_len > EXT_LEN_W'(EXT_LEN_MAX))) begin
			status = ST_EXTLEN;
		end else if (upd.seg_has_dot && upd.ext_nonalpha) begin
			status = ST_BADCHAR;
		end else begin
			status = ST_OK;
		end
	end

	assign nxt = last ? STATE_RESET : upd;

endmodule

`default_nettype wire

@@ design/fat_path_validator_top.sv @@
// Top level of the path validator: input register, segment state and result register.
`default_nettype none

// Channel   Dir  Payload              Role
// path      in   ch[7:0], last        one path byte per transaction
// result    out  status[2:0]          one status per path, on its last byte
//
// A new byte is accepted every cycle unless a last byte waits in the input register on a stalled result.
// A byte is first held in the input register; the segment state then updates
// from it, and for a last byte the result register updates with it. A status
// is therefore presented from the result register after that update.
// A stalled result holds the input register only when it holds a last byte;
// other bytes keep flowing. Reset returns the block to awaiting a new path.

module fat_path_validator_top
	import fpv_pkg::*;
#(
	parameter int MAX_SEG_LEN = MAX_SEG_LEN_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	fpv_path_if.sink            path,
	fpv_result_if.source        result
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// Segment state and result register.
	seg_state_t st_q;
	seg_state_t st_nxt;
	status_t    status_nxt;
	logic       out_valid_q;
	status_t    out_status_q;

	logic consume;

	// A byte in the input register moves on unless it is a last byte and the
	// result register is still full and not being drained.
	assign consume = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign path.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (path.ready) begin
			valid_s1 <= path.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (path.valid && path.ready) begin
			ch_s1 <= path.ch;
			last_s1 <= path.last;
		end
	end

	fpv_step #(
		.MAX_SEG_LEN(MAX_SEG_LEN)
	) u_step (
		.cur    (st_q),
		.ch     (ch_s1),
		.last   (last_s1),
		.nxt    (st_nxt),
		.status (status_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (consume) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_status_q <= status_nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = out_status_q;

	// The state is back at its reset value after the last byte of a path.
	a_clear_after_path: assert property (@(posedge clk) disable iff (!arst_n)
		consume && last_s1 |=> st_q == STATE_RESET)
		else $error("segment state not cleared after end of path");

	// A path that is not rooted never records an error.
	a_bypass_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bypass |-> st_q.err_code == ST_OK)
		else $error("error latched on an unrooted path");

	// The extension counter saturates and never runs past the segment length.
	a_ext_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.ext_len <= EXT_LEN_W'(EXT_LEN_SAT) &&
		SEG_LEN_W'(st_q.ext_len) <= st_q.seg_len)
		else $error("extension length out of bounds");

	// The segment length stays within the limit.
	a_seg_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.seg_len <= SEG_LEN_W'(MAX_SEG_LEN))
		else $error("segment length beyond limit");

	// A last byte is never consumed while the result register is full and stalled.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready |-> !(consume && last_s1))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
